FILE: design/saqg_pkg.sv
package saqg_pkg;

	// phase accumulator format
	localparam int PHASE_FRAC_BITS = 16;
	localparam int PHASE_W         = 32;

	// field widths
	localparam int TS_W      = 24;
	localparam int TS_FRAC   = 16;
	localparam int RATE_W    = 20;
	localparam int RATE_FRAC = 8;
	localparam int START_W   = 10;
	localparam int LEN_W     = 11;
	localparam int PIX_W     = 13;
	localparam int POS_W     = 16;
	localparam int POS_FRAC  = 4;
	localparam int UV_W      = 17;
	localparam int UV_FRAC   = 16;
	localparam int FRAME_W   = 11;
	localparam int FRAME_MAX = 2 ** FRAME_W - 1;

	// derived arithmetic widths
	localparam int PROD_W    = TS_W + RATE_W;
	localparam int INC_SHIFT = TS_FRAC + RATE_FRAC - PHASE_FRAC_BITS;
	localparam int INC_W     = PROD_W - INC_SHIFT;
	localparam int SUM_W     = ((INC_W > PHASE_W) ? INC_W : PHASE_W) + 1;
	localparam int IS_W      = SUM_W - PHASE_FRAC_BITS;
	localparam int IP_W      = PHASE_W - PHASE_FRAC_BITS;
	localparam int LPH_W     = LEN_W + PHASE_FRAC_BITS;
	localparam int QD_W      = POS_W + 3;
	localparam int MUL_W     = 2 * PIX_W;
	localparam int TEXD_W    = PIX_W + UV_FRAC;
	localparam int THI_W     = TEXD_W - UV_W;

	// shared divider
	localparam int NUM_DIV = 4;
	localparam int DIV_W   = (IS_W > UV_W) ? IS_W : UV_W;
	localparam int DVS_W   = PIX_W;
	localparam int CNT_W   = $clog2(DIV_W + 1);

	// configuration port
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANIM_START   = 3'd0,
		REG_ANIM_LENGTH  = 3'd1,
		REG_ANIM_RATE    = 3'd2,
		REG_LOOP_MODE    = 3'd3,
		REG_TILE_WIDTH   = 3'd4,
		REG_TILE_HEIGHT  = 3'd5,
		REG_ATLAS_WIDTH  = 3'd6,
		REG_ATLAS_HEIGHT = 3'd7
	} cfg_reg_e;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_SUM,
		S_D1S,
		S_D1W,
		S_FRM,
		S_D2S,
		S_D2W,
		S_GEO,
		S_TMUL,
		S_D3S,
		S_D3W,
		S_WB
	} ctrl_state_e;

	typedef struct packed {
		logic [TS_W-1:0]         time_step;
		logic signed [POS_W-1:0] center_x;
		logic signed [POS_W-1:0] center_y;
	} step_item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] left_x;
		logic signed [POS_W-1:0] bottom_y;
		logic signed [POS_W-1:0] right_x;
		logic signed [POS_W-1:0] top_y;
		logic [UV_W-1:0]         u_left;
		logic [UV_W-1:0]         u_right;
		logic [UV_W-1:0]         v_low;
		logic [UV_W-1:0]         v_high;
		logic [FRAME_W-1:0]      frame_index;
		logic                    out_of_sheet;
	} quad_item_t;

	typedef struct packed {
		logic load_in;
		logic mul;
		logic sum;
		logic div1_start;
		logic frame;
		logic div2_start;
		logic geo;
		logic tmul;
		logic div3_start;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_sts_t;

endpackage

FILE: design/saqg_ifs.sv
interface saqg_step_if;
	import saqg_pkg::*;

	logic       valid;
	logic       ready;
	step_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface saqg_quad_if;
	import saqg_pkg::*;

	logic       valid;
	logic       ready;
	quad_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/saqg_div.sv
module saqg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [saqg_pkg::DIV_W-1:0]    dividend,
	input  logic [saqg_pkg::DVS_W-1:0]    divisor,
	input  logic [saqg_pkg::DVS_W-1:0]    init_rem,
	input  logic [saqg_pkg::CNT_W-1:0]    steps,
	output logic [saqg_pkg::DIV_W-1:0]    quo,
	output logic [saqg_pkg::DVS_W-1:0]    rem,
	output logic                          done
);
	import saqg_pkg::*;

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DIV_W-1:0] dq_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             fits;

	// one restoring step per cycle; dividend is left aligned, quotient shifts in at the bottom
	always_comb begin
		trial = {rem_q, dq_q[DIV_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= steps;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= init_rem;
			dvs_q <= divisor;
			dq_q  <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dq_q  <= {dq_q[DIV_W-2:0], fits};
		end
	end

	assign quo  = dq_q;
	assign rem  = rem_q;
	assign done = (cnt_q == '0);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && steps != '0) |=> !done)
		else $error("divider reports done right after a non-empty start");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(!start && !done) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("divider step count skipped or stalled");

endmodule

FILE: design/saqg_ctrl.sv
module saqg_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_valid,
	output logic                  step_ready,
	output logic                  quad_valid,
	input  logic                  quad_ready,
	output saqg_pkg::ctrl_cmd_t   cmd,
	input  saqg_pkg::dp_sts_t     sts
);
	import saqg_pkg::*;

	ctrl_state_e state_q;
	ctrl_state_e state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		step_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				step_ready = 1'b1;
				if (step_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_D1S;
			end
			S_D1S: begin
				cmd.div1_start = 1'b1;
				state_d        = S_D1W;
			end
			S_D1W: begin
				if (sts.div_done) state_d = S_FRM;
			end
			S_FRM: begin
				cmd.frame = 1'b1;
				state_d   = S_D2S;
			end
			S_D2S: begin
				cmd.div2_start = 1'b1;
				state_d        = S_D2W;
			end
			S_D2W: begin
				if (sts.div_done) state_d = S_GEO;
			end
			S_GEO: begin
				cmd.geo = 1'b1;
				state_d = S_TMUL;
			end
			S_TMUL: begin
				cmd.tmul = 1'b1;
				state_d  = S_D3S;
			end
			S_D3S: begin
				cmd.div3_start = 1'b1;
				state_d        = S_D3W;
			end
			S_D3W: begin
				if (sts.div_done) state_d = S_WB;
			end
			S_WB: begin
				// hold here while the previous result still sits in the output register
				if (!out_valid_q || quad_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (quad_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign quad_valid = out_valid_q;

	a_out_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_WB))
		else $error("result raised outside write-back");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !quad_ready) |-> !cmd.load_out)
		else $error("pending result overwritten");

endmodule

FILE: design/saqg_dp.sv
module saqg_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [saqg_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [saqg_pkg::CFG_W-1:0]        cfg_data,
	input  saqg_pkg::ctrl_cmd_t               cmd,
	input  saqg_pkg::step_item_t              step_item,
	output saqg_pkg::dp_sts_t                 sts,
	output saqg_pkg::quad_item_t              quad_item
);
	import saqg_pkg::*;

	function automatic logic signed [POS_W-1:0] sat16(input logic signed [QD_W-1:0] v);
		logic [QD_W-POS_W:0] top;
		top = v[QD_W-1:POS_W-1];
		if (v[QD_W-1] && top != '1) begin
			sat16 = {1'b1, {(POS_W-1){1'b0}}};
		end else if (!v[QD_W-1] && top != '0) begin
			sat16 = {1'b0, {(POS_W-1){1'b1}}};
		end else begin
			sat16 = v[POS_W-1:0];
		end
	endfunction

	function automatic logic [UV_W-1:0] uv_sat(input logic big, input logic [UV_W-1:0] q);
		logic [UV_W-1:0] one;
		one = UV_W'(1) << UV_FRAC;
		uv_sat = (big || q > one) ? one : q;
	endfunction

	// configuration
	logic [START_W-1:0] start_q;
	logic [LEN_W-1:0]   len_q;
	logic [RATE_W-1:0]  rate_q;
	logic               loop_q;
	logic [PIX_W-1:0]   tw_q, th_q, aw_q, ah_q;
	logic [PHASE_W-1:0] phase_q;

	logic [LEN_W-1:0]   len_e;
	logic [PIX_W-1:0]   tw_e, th_e, aw_e, ah_e;

	// per request
	step_item_t         in_q;
	logic [PROD_W-1:0]  prod_q;
	logic [SUM_W-1:0]   sum_q;
	logic [DVS_W-1:0]   cols_q, rows_q;
	logic [FRAME_W-1:0] frame_q;
	logic [PIX_W-1:0]   fx_q, fy_q;
	logic               oos_q;
	logic signed [POS_W-1:0] left_q, bottom_q, right_q, top_q;
	logic [PIX_W-1:0]   px_q [NUM_DIV];
	logic               big_q [NUM_DIV];
	quad_item_t         quad_q;

	// dividers
	logic               div_go;
	logic [DIV_W-1:0]   dvd_v [NUM_DIV];
	logic [DVS_W-1:0]   dvs_v [NUM_DIV];
	logic [DVS_W-1:0]   init_v [NUM_DIV];
	logic [CNT_W-1:0]   steps_v [NUM_DIV];
	logic [DIV_W-1:0]   quo_v [NUM_DIV];
	logic [DVS_W-1:0]   rem_v [NUM_DIV];
	logic [NUM_DIV-1:0] done_v;

	// phase and frame
	logic [63:0]        sum64, lph64;
	logic [LPH_W-1:0]   lph;
	logic [PHASE_W-1:0] phase_loop, phase_once, phase_n;
	logic [IP_W-1:0]    ipart;
	logic [LEN_W-1:0]   len_m1, off;
	logic [FRAME_W:0]   frame_sum;
	logic [FRAME_W-1:0] frame_n;

	// sheet geometry
	logic [FRAME_W-1:0] rowi;
	logic               no_sheet, row_over;
	logic [DVS_W-1:0]   rowc;
	logic [PIX_W-1:0]   fx_n, fy_n;
	logic signed [QD_W-1:0] x1, y1, x2, y2;

	// texture
	logic [MUL_W-1:0]   mul_u, mul_v;
	logic [TEXD_W-1:0]  texd [NUM_DIV];
	logic [PIX_W-1:0]   size_v [NUM_DIV];

	always_comb begin
		len_e = (len_q == '0) ? LEN_W'(1) : len_q;
		tw_e  = (tw_q == '0) ? PIX_W'(1) : tw_q;
		th_e  = (th_q == '0) ? PIX_W'(1) : th_q;
		aw_e  = (aw_q == '0) ? PIX_W'(1) : aw_q;
		ah_e  = (ah_q == '0) ? PIX_W'(1) : ah_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			len_q   <= LEN_W'(1);
			rate_q  <= '0;
			loop_q  <= 1'b0;
			tw_q    <= PIX_W'(1);
			th_q    <= PIX_W'(1);
			aw_q    <= PIX_W'(1);
			ah_q    <= PIX_W'(1);
			phase_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_e'(cfg_idx))
				REG_ANIM_START: begin
					start_q <= cfg_data[START_W-1:0];
					phase_q <= '0;
				end
				REG_ANIM_LENGTH: begin
					len_q   <= cfg_data[LEN_W-1:0];
					phase_q <= '0;
				end
				REG_ANIM_RATE: begin
					rate_q  <= cfg_data[RATE_W-1:0];
					phase_q <= '0;
				end
				REG_LOOP_MODE: begin
					loop_q  <= cfg_data[0];
					phase_q <= '0;
				end
				REG_TILE_WIDTH:   tw_q <= cfg_data[PIX_W-1:0];
				REG_TILE_HEIGHT:  th_q <= cfg_data[PIX_W-1:0];
				REG_ATLAS_WIDTH:  aw_q <= cfg_data[PIX_W-1:0];
				REG_ATLAS_HEIGHT: ah_q <= cfg_data[PIX_W-1:0];
			endcase
		end else if (cmd.frame) begin
			phase_q <= phase_n;
		end
	end

	// new phase: loop mode keeps (integer mod length) with the fraction, one-shot saturates
	always_comb begin
		sum64      = 64'(sum_q);
		lph        = {rem_v[0][LEN_W-1:0], sum_q[PHASE_FRAC_BITS-1:0]};
		lph64      = 64'(lph);
		phase_loop = (lph64[63:PHASE_W] != '0) ? '1 : lph64[PHASE_W-1:0];
		phase_once = (sum64[63:PHASE_W] != '0) ? '1 : sum64[PHASE_W-1:0];
		phase_n    = loop_q ? phase_loop : phase_once;
		ipart      = phase_n[PHASE_W-1:PHASE_FRAC_BITS];
		len_m1     = len_e - LEN_W'(1);
		// in loop mode ipart is already below the length, so the clamp is harmless
		off        = (32'(ipart) > 32'(len_m1)) ? len_m1 : LEN_W'(ipart);
		frame_sum  = (FRAME_W+1)'(start_q) + (FRAME_W+1)'(off);
		frame_n    = (frame_sum > (FRAME_W+1)'(FRAME_MAX)) ? FRAME_W'(FRAME_MAX)
		                                                 : frame_sum[FRAME_W-1:0];
	end

	always_comb begin
		rowi     = quo_v[0][FRAME_W-1:0];
		no_sheet = (cols_q == '0) || (rows_q == '0);
		row_over = (DVS_W'(rowi) >= rows_q);
		rowc     = row_over ? rows_q - DVS_W'(1) : DVS_W'(rowi);
		fx_n     = no_sheet ? '0 : rem_v[0];
		fy_n     = no_sheet ? '0 : rows_q - DVS_W'(1) - rowc;
		x1       = QD_W'(in_q.center_x) - (QD_W'(tw_e >> 1) << POS_FRAC);
		y1       = QD_W'(in_q.center_y) - (QD_W'(th_e >> 1) << POS_FRAC);
		x2       = x1 + (QD_W'(tw_e) << POS_FRAC);
		y2       = y1 + (QD_W'(th_e) << POS_FRAC);
		mul_u    = MUL_W'(fx_q) * MUL_W'(tw_e);
		mul_v    = MUL_W'(fy_q) * MUL_W'(th_e);
	end

	// (edge << 16) + size/2, split so the divider sees a remainder already below the size
	always_comb begin
		for (int k = 0; k < NUM_DIV; k++) begin
			size_v[k] = (k < 2) ? aw_e : ah_e;
			texd[k]   = (TEXD_W'(px_q[k]) << UV_FRAC) + TEXD_W'(size_v[k] >> 1);
		end
	end

	always_comb begin
		div_go = cmd.div1_start | cmd.div2_start | cmd.div3_start;
		for (int k = 0; k < NUM_DIV; k++) begin
			dvd_v[k]   = '0;
			dvs_v[k]   = '0;
			init_v[k]  = '0;
			steps_v[k] = '0;
		end
		priority if (cmd.div1_start) begin
			dvd_v[0]   = DIV_W'(sum_q[SUM_W-1:PHASE_FRAC_BITS]) << (DIV_W - IS_W);
			dvs_v[0]   = DVS_W'(len_e);
			steps_v[0] = CNT_W'(IS_W);
			dvd_v[1]   = DIV_W'(aw_e) << (DIV_W - PIX_W);
			dvs_v[1]   = tw_e;
			steps_v[1] = CNT_W'(PIX_W);
			dvd_v[2]   = DIV_W'(ah_e) << (DIV_W - PIX_W);
			dvs_v[2]   = th_e;
			steps_v[2] = CNT_W'(PIX_W);
		end else if (cmd.div2_start) begin
			dvd_v[0]   = DIV_W'(frame_q) << (DIV_W - FRAME_W);
			dvs_v[0]   = cols_q;
			steps_v[0] = CNT_W'(FRAME_W);
		end else if (cmd.div3_start) begin
			for (int k = 0; k < NUM_DIV; k++) begin
				dvd_v[k]   = DIV_W'(texd[k][UV_W-1:0]) << (DIV_W - UV_W);
				dvs_v[k]   = size_v[k];
				init_v[k]  = DVS_W'(texd[k][TEXD_W-1:UV_W]);
				steps_v[k] = CNT_W'(UV_W);
			end
		end
	end

	for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
		saqg_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (div_go),
			.dividend (dvd_v[g]),
			.divisor  (dvs_v[g]),
			.init_rem (init_v[g]),
			.steps    (steps_v[g]),
			.quo      (quo_v[g]),
			.rem      (rem_v[g]),
			.done     (done_v[g])
		);
	end

	assign sts.div_done = &done_v;

	always_ff @(posedge clk) begin
		if (cmd.load_in) in_q <= step_item;
		if (cmd.mul) prod_q <= PROD_W'(in_q.time_step) * PROD_W'(rate_q);
		if (cmd.sum) sum_q <= SUM_W'(phase_q) + SUM_W'(prod_q[PROD_W-1:INC_SHIFT]);
		if (cmd.frame) begin
			cols_q  <= quo_v[1][DVS_W-1:0];
			rows_q  <= quo_v[2][DVS_W-1:0];
			frame_q <= frame_n;
		end
		if (cmd.geo) begin
			fx_q     <= fx_n;
			fy_q     <= fy_n;
			oos_q    <= no_sheet || row_over;
			left_q   <= sat16(x1);
			bottom_q <= sat16(y1);
			right_q  <= sat16(x2);
			top_q    <= sat16(y2);
		end
		if (cmd.tmul) begin
			// edges stay inside the sheet width and height, so 13 bits hold them
			px_q[0] <= mul_u[PIX_W-1:0];
			px_q[1] <= mul_u[PIX_W-1:0] + tw_e;
			px_q[2] <= mul_v[PIX_W-1:0];
			px_q[3] <= mul_v[PIX_W-1:0] + th_e;
		end
		if (cmd.div3_start) begin
			for (int k = 0; k < NUM_DIV; k++) begin
				big_q[k] <= (DVS_W'(texd[k][TEXD_W-1:UV_W]) >= size_v[k]);
			end
		end
		if (cmd.load_out) begin
			quad_q.left_x       <= left_q;
			quad_q.bottom_y     <= bottom_q;
			quad_q.right_x      <= right_q;
			quad_q.top_y        <= top_q;
			quad_q.u_left       <= uv_sat(big_q[0], quo_v[0][UV_W-1:0]);
			quad_q.u_right      <= uv_sat(big_q[1], quo_v[1][UV_W-1:0]);
			quad_q.v_low        <= uv_sat(big_q[2], quo_v[2][UV_W-1:0]);
			quad_q.v_high       <= uv_sat(big_q[3], quo_v[3][UV_W-1:0]);
			quad_q.frame_index  <= frame_q;
			quad_q.out_of_sheet <= oos_q;
		end
	end

	assign quad_item = quad_q;

endmodule

FILE: design/sprite_anim_quad_gen.sv
// Sprite-sheet animation and quad generator.
// step_ch takes one request per drawn sprite: time step (Q8.16) and center (Q12.4).
// Each request advances the animation phase by time_step * anim_rate, picks the
// sheet frame, and returns on quad_ch the quad corners (Q12.4, saturated), the
// frame's texture coordinates (Q1.16), the frame number and an out-of-sheet flag.
// Registers are written through cfg_we/cfg_idx/cfg_data; the user must write
// them only while no request is in flight, as the block does not enforce this.
// A write to any of the four animation registers clears the phase.
// Each request makes three passes through the radix-2 dividers, one quotient
// bit per cycle: phase modulo length plus sheet columns and rows (21 steps),
// frame by columns (11 steps), and the four texture coordinates in parallel
// (17 steps); a new request is taken only once the last one is written back.
// The result sits in an output register until taken; the next request is
// accepted and computed meanwhile, and waits in write-back while quad_ch stalls.
// Reset restores the register defaults, clears the phase and drops any pending
// result.
module sprite_anim_quad_gen (
	input  logic                              clk,
	input  logic                              arst_n,
	saqg_step_if.sink                         step_ch,
	saqg_quad_if.source                       quad_ch,
	input  logic                              cfg_we,
	input  logic [saqg_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [saqg_pkg::CFG_W-1:0]        cfg_data
);
	import saqg_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	saqg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_valid (step_ch.valid),
		.step_ready (step_ch.ready),
		.quad_valid (quad_ch.valid),
		.quad_ready (quad_ch.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	saqg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.step_item (step_ch.data),
		.sts       (sts),
		.quad_item (quad_ch.data)
	);

endmodule
